### rtl/pric_pkg.sv
// Package for the pump run interlock controller.
// Holds the time width, mode, reason, action and register codes, and the request and result item types.
// No dependencies.
`timescale 1ns / 1ps

package pric_pkg;

   localparam int TIME_BITS = 16;

   localparam int CFG_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_MANUAL = 2'd1;
   localparam logic [1:0] ACT_SCHED = 2'd2;
   localparam logic [1:0] ACT_STOP = 2'd3;

   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_MANUAL = 3'd1;
   localparam logic [2:0] MODE_SCHED = 3'd2;
   localparam logic [2:0] MODE_COOL = 3'd3;
   localparam logic [2:0] MODE_LOCK = 3'd4;

   localparam logic [2:0] WHY_TIMER = 3'd0;
   localparam logic [2:0] WHY_LOW = 3'd1;
   localparam logic [2:0] WHY_FAULT = 3'd2;
   localparam logic [2:0] WHY_MAXRUN = 3'd3;
   localparam logic [2:0] WHY_COOL = 3'd4;
   localparam logic [2:0] WHY_USER = 3'd5;

   localparam logic KIND_MANUAL = 1'b0;
   localparam logic KIND_SCHED = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MANUAL_MAX = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCHED_MAX = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COOLDOWN = 2'd2;

   localparam logic [CFG_BITS-1:0] MANUAL_MAX_RESET = 16'd300;
   localparam logic [CFG_BITS-1:0] SCHED_MAX_RESET = 16'd600;
   localparam logic [CFG_BITS-1:0] COOLDOWN_RESET = 16'd60;

   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 64;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] req_seconds;
      logic [2:0]  halt_code;
      logic        water_ok;
   } req_item_type;

   typedef struct packed {
      logic        pump_on;
      logic [2:0]  pump_mode;
      logic [15:0] remaining_sec;
      logic        run_started;
      logic [15:0] granted_sec;
      logic        run_skipped;
      logic        run_stopped;
      logic [2:0]  end_reason;
      logic        run_kind;
      logic [15:0] run_seconds;
   } rsp_item_type;

endpackage

### rtl/pump_run_interlock_controller.sv
// Top level of the pump run interlock controller: input register, decision logic, result register.
// Depends on pric_pkg.
//
//   channel  | direction | ports                                     | accepted when
//   req      | in        | req_tvalid req_tready req_tdata req_tuser | req_tvalid && req_tready
//   rsp      | out       | rsp_tvalid rsp_tready rsp_tdata           | rsp_tvalid && rsp_tready
//   csr      | in        | csr_valid csr_ready csr_index csr_wdata   | csr_valid && csr_ready
//
// One transaction per cycle is sustained while the result side is ready; an accepted request
// passes through the input register and then the result register before its result is valid.
// The decision logic between the two registers is combinational.
// Reset is synchronous and active high; it restores the configuration, the valid flags and the run state.
// A stalled result holds the result register, and the input register then holds the next request.
// Configuration writes are always taken; csr_ready is tied high.
`timescale 1ns / 1ps

module pump_run_interlock_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: req_seconds[15:0], halt_code[18:16], water_ok[19], zero fill.
   input  logic [pric_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // tuser: action[1:0].
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: pump_on[0], pump_mode[3:1], remaining_sec[19:4], run_started[20],
   // granted_sec[36:21], run_skipped[37], run_stopped[38], end_reason[41:39],
   // run_kind[42], run_seconds[58:43], zero fill.
   output logic [pric_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [pric_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pric_pkg::CFG_BITS-1:0] csr_wdata
);

   localparam int TB = pric_pkg::TIME_BITS;
   localparam int EXT_BITS = (TB > 16) ? TB : 16;
   localparam logic [TB-1:0] TIME_MAX = '1;

   function automatic logic [15:0] sat16(input logic [TB-1:0] v);
      logic [EXT_BITS-1:0] ext;
      ext = EXT_BITS'(v);
      return (ext > EXT_BITS'(17'h0FFFF)) ? 16'hFFFF : ext[15:0];
   endfunction

   logic [pric_pkg::CFG_BITS-1:0] manual_max_ff;
   logic [pric_pkg::CFG_BITS-1:0] sched_max_ff;
   logic [pric_pkg::CFG_BITS-1:0] cooldown_cfg_ff;

   logic                  in_valid_ff;
   pric_pkg::req_item_type in_item_ff;
   logic                  out_valid_ff;
   pric_pkg::rsp_item_type out_item_ff;

   logic          running_ff, running_in;
   logic          kind_ff, kind_in;
   logic [TB-1:0] elapsed_ff, elapsed_in;
   logic [TB-1:0] length_ff, length_in;
   logic [TB-1:0] cool_ff, cool_in;
   logic [2:0]    mode_ff, mode_in;

   pric_pkg::rsp_item_type rsp_in;

   logic advance;
   logic out_free;

   assign out_free = !out_valid_ff || rsp_tready;
   assign advance = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {5'd0, out_item_ff.run_seconds, out_item_ff.run_kind,
                       out_item_ff.end_reason, out_item_ff.run_stopped,
                       out_item_ff.run_skipped, out_item_ff.granted_sec,
                       out_item_ff.run_started, out_item_ff.remaining_sec,
                       out_item_ff.pump_mode, out_item_ff.pump_on};

   always_comb begin
      logic [2:0]  why;
      logic        ok;
      logic        started;
      logic        skipped;
      logic [2:0]  skip_reason;
      logic        req_kind;
      logic [15:0] cap;
      logic [15:0] granted16;
      logic [TB-1:0] granted;
      logic [TB-1:0] remaining;
      logic        stopped;
      logic [2:0]  stop_why;
      logic [TB-1:0] stop_secs;
      logic        rest;

      running_in = running_ff;
      kind_in = kind_ff;
      elapsed_in = elapsed_ff;
      length_in = length_ff;
      cool_in = cool_ff;
      mode_in = mode_ff;
      ok = in_item_ff.water_ok;
      why = (in_item_ff.halt_code > pric_pkg::WHY_USER) ? pric_pkg::WHY_USER
                                                        : in_item_ff.halt_code;
      started = 1'b0;
      skipped = 1'b0;
      skip_reason = pric_pkg::WHY_TIMER;
      req_kind = pric_pkg::KIND_MANUAL;
      cap = '0;
      granted16 = '0;
      granted = '0;
      remaining = '0;
      stopped = 1'b0;
      stop_why = pric_pkg::WHY_TIMER;
      stop_secs = '0;
      rest = 1'b0;

      unique case (in_item_ff.action)
         pric_pkg::ACT_TICK: begin
            if (running_in && elapsed_in != TIME_MAX) begin
               elapsed_in = elapsed_in + TB'(1);
            end
            if (cool_in != '0) begin
               cool_in = cool_in - TB'(1);
            end
         end
         pric_pkg::ACT_MANUAL, pric_pkg::ACT_SCHED: begin
            req_kind = (in_item_ff.action == pric_pkg::ACT_SCHED);
            if (!ok) begin
               mode_in = pric_pkg::MODE_LOCK;
               skipped = 1'b1;
               skip_reason = pric_pkg::WHY_LOW;
            end else if (cool_in != '0) begin
               mode_in = pric_pkg::MODE_COOL;
               skipped = 1'b1;
               skip_reason = pric_pkg::WHY_COOL;
            end else begin
               cap = req_kind ? sched_max_ff : manual_max_ff;
               granted16 = (in_item_ff.req_seconds > cap) ? cap : in_item_ff.req_seconds;
               granted = TB'(granted16);
               running_in = 1'b1;
               kind_in = req_kind;
               elapsed_in = '0;
               length_in = granted;
               mode_in = req_kind ? pric_pkg::MODE_SCHED : pric_pkg::MODE_MANUAL;
               started = 1'b1;
            end
         end
         pric_pkg::ACT_STOP: begin
            if (running_in) begin
               stopped = 1'b1;
               stop_why = why;
               stop_secs = elapsed_in;
               running_in = 1'b0;
               rest = kind_in || why == pric_pkg::WHY_LOW || why == pric_pkg::WHY_FAULT
                      || why == pric_pkg::WHY_MAXRUN;
               if (rest) begin
                  cool_in = TB'(cooldown_cfg_ff);
                  mode_in = pric_pkg::MODE_COOL;
               end else begin
                  cool_in = '0;
                  mode_in = ok ? pric_pkg::MODE_IDLE : pric_pkg::MODE_LOCK;
               end
            end
         end
         default: begin
         end
      endcase

      if (running_in) begin
         remaining = (elapsed_in >= length_in) ? '0 : length_in - elapsed_in;
         if (!ok || elapsed_in >= length_in) begin
            stopped = 1'b1;
            stop_why = ok ? pric_pkg::WHY_TIMER : pric_pkg::WHY_LOW;
            stop_secs = elapsed_in;
            running_in = 1'b0;
            rest = kind_in || !ok;
            if (rest) begin
               cool_in = TB'(cooldown_cfg_ff);
               mode_in = pric_pkg::MODE_COOL;
            end else begin
               cool_in = '0;
               mode_in = pric_pkg::MODE_IDLE;
            end
         end
      end else if (mode_in == pric_pkg::MODE_COOL && cool_in == '0) begin
         mode_in = ok ? pric_pkg::MODE_IDLE : pric_pkg::MODE_LOCK;
      end else if (!ok && mode_in == pric_pkg::MODE_IDLE) begin
         mode_in = pric_pkg::MODE_LOCK;
      end else if (ok && mode_in == pric_pkg::MODE_LOCK) begin
         mode_in = pric_pkg::MODE_IDLE;
      end
      if (!running_in) begin
         remaining = '0;
      end

      rsp_in.pump_on = running_in;
      rsp_in.pump_mode = mode_in;
      rsp_in.remaining_sec = sat16(remaining);
      rsp_in.run_started = started;
      rsp_in.granted_sec = sat16(granted);
      rsp_in.run_skipped = skipped;
      rsp_in.run_stopped = stopped;
      if (stopped) begin
         rsp_in.end_reason = stop_why;
         rsp_in.run_kind = kind_in;
      end else if (skipped || started) begin
         rsp_in.end_reason = skip_reason;
         rsp_in.run_kind = req_kind;
      end else begin
         rsp_in.end_reason = pric_pkg::WHY_TIMER;
         rsp_in.run_kind = pric_pkg::KIND_MANUAL;
      end
      rsp_in.run_seconds = sat16(stop_secs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         manual_max_ff <= pric_pkg::MANUAL_MAX_RESET;
         sched_max_ff <= pric_pkg::SCHED_MAX_RESET;
         cooldown_cfg_ff <= pric_pkg::COOLDOWN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pric_pkg::CSR_MANUAL_MAX: manual_max_ff <= csr_wdata;
            pric_pkg::CSR_SCHED_MAX: sched_max_ff <= csr_wdata;
            pric_pkg::CSR_COOLDOWN: cooldown_cfg_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.action <= req_tuser;
         in_item_ff.req_seconds <= req_tdata[15:0];
         in_item_ff.halt_code <= req_tdata[18:16];
         in_item_ff.water_ok <= req_tdata[19];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         kind_ff <= pric_pkg::KIND_MANUAL;
         elapsed_ff <= '0;
         length_ff <= '0;
         cool_ff <= '0;
         mode_ff <= pric_pkg::MODE_IDLE;
      end else if (advance) begin
         running_ff <= running_in;
         kind_ff <= kind_in;
         elapsed_ff <= elapsed_in;
         length_ff <= length_in;
         cool_ff <= cool_in;
         mode_ff <= mode_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_run_mode: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (mode_ff == pric_pkg::MODE_MANUAL || mode_ff == pric_pkg::MODE_SCHED))
      else $error("running with a mode that is not a run mode");

   a_run_no_cool: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> cool_ff == '0)
      else $error("cooldown pending while running");

   a_on_has_time: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.pump_on) |-> out_item_ff.remaining_sec != 16'd0)
      else $error("pump on with no time remaining");

   a_instant_end: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.run_started && out_item_ff.run_stopped)
      |-> (out_item_ff.granted_sec == 16'd0 && out_item_ff.end_reason == pric_pkg::WHY_TIMER))
      else $error("run started and stopped in one transaction with time granted");
`endif

endmodule

### dv/tb_pump_run_interlock_controller.sv
// Testbench for pump_run_interlock_controller: directed and random run, stop and tick traffic.
// Each accepted result is checked against a cycle-free predictor of the run, cooldown and
// lockout logic. Depends on pric_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_pump_run_interlock_controller;

   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [pric_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [1:0] req_tuser = pric_pkg::ACT_TICK;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [pric_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [pric_pkg::CSR_INDEX_BITS-1:0] csr_index = pric_pkg::CSR_MANUAL_MAX;
   logic [pric_pkg::CFG_BITS-1:0] csr_wdata = '0;

   logic [15:0] cfg_manual_max;
   logic [15:0] cfg_sched_max;
   logic [15:0] cfg_cooldown;

   logic pm_running;
   logic pm_kind;
   logic [15:0] pm_elapsed;
   logic [15:0] pm_length;
   logic [15:0] pm_cool_left;
   logic [2:0] pm_mode;
   logic stop_seen;
   logic [2:0] stop_why;
   logic [15:0] stop_secs;

   pric_pkg::rsp_item_type status_q[$];
   int error_count = 0;
   int idle_cycles = 0;
   int rx_wait = 0;
   bit steady_flow = 1'b0;

   pump_run_interlock_controller dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic void end_pump_run(input logic [2:0] why, input logic ok);
      if (!pm_running) return;
      stop_seen = 1'b1;
      stop_why = why;
      stop_secs = pm_elapsed;
      pm_running = 1'b0;
      if (pm_kind == pric_pkg::KIND_SCHED || why == pric_pkg::WHY_LOW
          || why == pric_pkg::WHY_FAULT || why == pric_pkg::WHY_MAXRUN) begin
         pm_cool_left = cfg_cooldown;
         pm_mode = pric_pkg::MODE_COOL;
      end else begin
         pm_cool_left = '0;
         pm_mode = ok ? pric_pkg::MODE_IDLE : pric_pkg::MODE_LOCK;
      end
   endfunction

   function automatic pric_pkg::rsp_item_type pump_step(input pric_pkg::req_item_type it);
      pric_pkg::rsp_item_type r;
      logic [2:0] why;
      logic ok;
      logic req_kind;
      logic started;
      logic skipped;
      logic [2:0] skip_why;
      logic [15:0] cap;
      logic [15:0] granted;
      logic [15:0] remaining;
      r = '0;
      why = it.halt_code;
      ok = it.water_ok;
      req_kind = pric_pkg::KIND_MANUAL;
      started = 1'b0;
      skipped = 1'b0;
      skip_why = pric_pkg::WHY_TIMER;
      granted = '0;
      remaining = '0;
      stop_seen = 1'b0;
      stop_why = pric_pkg::WHY_TIMER;
      stop_secs = '0;
      if (why > pric_pkg::WHY_USER) why = pric_pkg::WHY_USER;

      case (it.action)
         pric_pkg::ACT_TICK: begin
            if (pm_running && pm_elapsed != 16'hFFFF) pm_elapsed++;
            if (pm_cool_left != 0) pm_cool_left--;
         end
         pric_pkg::ACT_MANUAL, pric_pkg::ACT_SCHED: begin
            req_kind = (it.action == pric_pkg::ACT_SCHED) ? pric_pkg::KIND_SCHED
                                                          : pric_pkg::KIND_MANUAL;
            if (!ok) begin
               pm_mode = pric_pkg::MODE_LOCK;
               skipped = 1'b1;
               skip_why = pric_pkg::WHY_LOW;
            end else if (pm_cool_left != 0) begin
               pm_mode = pric_pkg::MODE_COOL;
               skipped = 1'b1;
               skip_why = pric_pkg::WHY_COOL;
            end else begin
               cap = (req_kind == pric_pkg::KIND_SCHED) ? cfg_sched_max : cfg_manual_max;
               granted = (it.req_seconds > cap) ? cap : it.req_seconds;
               pm_running = 1'b1;
               pm_kind = req_kind;
               pm_elapsed = '0;
               pm_length = granted;
               pm_mode = (req_kind == pric_pkg::KIND_SCHED) ? pric_pkg::MODE_SCHED
                                                            : pric_pkg::MODE_MANUAL;
               started = 1'b1;
            end
         end
         default: end_pump_run(why, ok);
      endcase

      if (pm_running) begin
         remaining = (pm_elapsed >= pm_length) ? 16'd0 : pm_length - pm_elapsed;
         if (!ok) end_pump_run(pric_pkg::WHY_LOW, ok);
         else if (pm_elapsed >= pm_length) end_pump_run(pric_pkg::WHY_TIMER, ok);
      end else if (pm_mode == pric_pkg::MODE_COOL && pm_cool_left == 0) begin
         pm_mode = ok ? pric_pkg::MODE_IDLE : pric_pkg::MODE_LOCK;
      end else if (!ok && pm_mode == pric_pkg::MODE_IDLE) begin
         pm_mode = pric_pkg::MODE_LOCK;
      end else if (ok && pm_mode == pric_pkg::MODE_LOCK) begin
         pm_mode = pric_pkg::MODE_IDLE;
      end
      if (!pm_running) remaining = '0;

      r.pump_on = pm_running;
      r.pump_mode = pm_mode;
      r.remaining_sec = remaining;
      r.run_started = started;
      r.granted_sec = granted;
      r.run_skipped = skipped;
      r.run_stopped = stop_seen;
      r.run_seconds = stop_secs;
      if (stop_seen) begin
         r.end_reason = stop_why;
         r.run_kind = pm_kind;
      end else if (skipped || started) begin
         r.end_reason = skip_why;
         r.run_kind = req_kind;
      end
      return r;
   endfunction

   always @(posedge clock) begin : req_monitor
      pric_pkg::req_item_type seen;
      if (reset) begin
         cfg_manual_max = pric_pkg::MANUAL_MAX_RESET;
         cfg_sched_max = pric_pkg::SCHED_MAX_RESET;
         cfg_cooldown = pric_pkg::COOLDOWN_RESET;
         pm_running = 1'b0;
         pm_kind = pric_pkg::KIND_MANUAL;
         pm_elapsed = '0;
         pm_length = '0;
         pm_cool_left = '0;
         pm_mode = pric_pkg::MODE_IDLE;
      end else if (req_tvalid && req_tready) begin
         seen.action = req_tuser;
         seen.req_seconds = req_tdata[15:0];
         seen.halt_code = req_tdata[18:16];
         seen.water_ok = req_tdata[19];
         status_q.push_back(pump_step(seen));
      end
   end

   task automatic check_field(input string fname, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %0d, got %0d", fname, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_checker
      pric_pkg::rsp_item_type got;
      pric_pkg::rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pump_on = rsp_tdata[0];
         got.pump_mode = rsp_tdata[3:1];
         got.remaining_sec = rsp_tdata[19:4];
         got.run_started = rsp_tdata[20];
         got.granted_sec = rsp_tdata[36:21];
         got.run_skipped = rsp_tdata[37];
         got.run_stopped = rsp_tdata[38];
         got.end_reason = rsp_tdata[41:39];
         got.run_kind = rsp_tdata[42];
         got.run_seconds = rsp_tdata[58:43];
         if (status_q.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected result %h with nothing pending", rsp_tdata);
         end else begin
            want = status_q.pop_front();
            check_field("pump_on", 16'(want.pump_on), 16'(got.pump_on));
            check_field("pump_mode", 16'(want.pump_mode), 16'(got.pump_mode));
            check_field("remaining_sec", want.remaining_sec, got.remaining_sec);
            check_field("run_started", 16'(want.run_started), 16'(got.run_started));
            check_field("granted_sec", want.granted_sec, got.granted_sec);
            check_field("run_skipped", 16'(want.run_skipped), 16'(got.run_skipped));
            check_field("run_stopped", 16'(want.run_stopped), 16'(got.run_stopped));
            check_field("end_reason", 16'(want.end_reason), 16'(got.end_reason));
            check_field("run_kind", 16'(want.run_kind), 16'(got.run_kind));
            check_field("run_seconds", want.run_seconds, got.run_seconds);
         end
      end
   end

   always @(posedge clock) begin : rsp_pacing
      if (rsp_tvalid && rsp_tready) rx_wait = steady_flow ? 0 : $urandom_range(0, 7);
      else if (rx_wait > 0) rx_wait--;
      rsp_tready <= (rx_wait == 0);
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] act, input logic [15:0] dur,
                            input logic [2:0] why, input logic ok);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {4'b0000, ok, why, dur};
      do @(posedge clock); while (!req_tready);
      gap = steady_flow ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [pric_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [pric_pkg::CFG_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pric_pkg::CSR_MANUAL_MAX: cfg_manual_max = val;
         pric_pkg::CSR_SCHED_MAX: cfg_sched_max = val;
         pric_pkg::CSR_COOLDOWN: cfg_cooldown = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_limits(input logic [15:0] man_max, input logic [15:0] sch_max,
                             input logic [15:0] cool);
      drain_results();
      write_csr(pric_pkg::CSR_MANUAL_MAX, man_max);
      write_csr(pric_pkg::CSR_SCHED_MAX, sch_max);
      write_csr(pric_pkg::CSR_COOLDOWN, cool);
   endtask

   task automatic test_reset_defaults();
      send_item(pric_pkg::ACT_MANUAL, 16'd5, pric_pkg::WHY_TIMER, 1'b1);
      send_item(pric_pkg::ACT_TICK, 16'd0, pric_pkg::WHY_TIMER, 1'b1);
      send_item(pric_pkg::ACT_MANUAL, 16'd400, pric_pkg::WHY_TIMER, 1'b1);
      send_item(pric_pkg::ACT_STOP, 16'd0, pric_pkg::WHY_USER, 1'b1);
      send_item(pric_pkg::ACT_STOP, 16'd0, pric_pkg::WHY_FAULT, 1'b1);
      send_item(pric_pkg::ACT_SCHED, 16'hFFFF, pric_pkg::WHY_TIMER, 1'b1);
      send_item(pric_pkg::ACT_TICK, 16'hFFFF, 3'd7, 1'b1);
      send_item(pric_pkg::ACT_STOP, 16'd0, 3'd6, 1'b1);
      send_item(pric_pkg::ACT_MANUAL, 16'd10, pric_pkg::WHY_TIMER, 1'b1);
      send_item(pric_pkg::ACT_SCHED, 16'd10, pric_pkg::WHY_TIMER, 1'b0);
      send_item(pric_pkg::ACT_TICK, 16'd0, pric_pkg::WHY_TIMER, 1'b1);
      send_item(pric_pkg::ACT_TICK, 16'd0, pric_pkg::WHY_TIMER, 1'b0);
      // Let the default cooldown run out so that a run is granted again.
      repeat (60) send_item(pric_pkg::ACT_TICK, 16'd0, pric_pkg::WHY_TIMER, 1'b1);
      send_item(pric_pkg::ACT_MANUAL, 16'd3, pric_pkg::WHY_TIMER, 1'b1);
      send_item(pric_pkg::ACT_STOP, 16'd0, pric_pkg::WHY_MAXRUN, 1'b1);
   endtask

   task automatic test_zero_limits();
      set_limits(16'd0, 16'hFFFF, 16'd0);
      send_item(pric_pkg::ACT_MANUAL, 16'd100, pric_pkg::WHY_TIMER, 1'b1);
      send_item(pric_pkg::ACT_SCHED, 16'hFFFF, pric_pkg::WHY_TIMER, 1'b1);
      send_item(pric_pkg::ACT_MANUAL, 16'd0, pric_pkg::WHY_TIMER, 1'b0);
      send_item(pric_pkg::ACT_TICK, 16'd0, pric_pkg::WHY_TIMER, 1'b1);
      send_item(pric_pkg::ACT_SCHED, 16'd0, pric_pkg::WHY_TIMER, 1'b1);
      send_item(pric_pkg::ACT_TICK, 16'd0, pric_pkg::WHY_TIMER, 1'b0);
      send_item(pric_pkg::ACT_TICK, 16'd0, pric_pkg::WHY_TIMER, 1'b1);
      send_item(pric_pkg::ACT_SCHED, 16'd2, pric_pkg::WHY_TIMER, 1'b1);
      send_item(pric_pkg::ACT_TICK, 16'd0, pric_pkg::WHY_TIMER, 1'b1);
      send_item(pric_pkg::ACT_TICK, 16'd0, pric_pkg::WHY_TIMER, 1'b1);
      send_item(pric_pkg::ACT_TICK, 16'd0, pric_pkg::WHY_TIMER, 1'b1);
   endtask

   task automatic test_stop_reasons();
      set_limits(16'hFFFF, 16'd1, 16'd0);
      for (int r = 0; r < 8; r++) begin
         send_item(pric_pkg::ACT_MANUAL, 16'd50, pric_pkg::WHY_TIMER, 1'b1);
         send_item(pric_pkg::ACT_STOP, 16'd0, 3'(r), 1'b1);
      end
   endtask

   task automatic test_random_traffic(input int count, input logic [15:0] man_max,
                                      input logic [15:0] sch_max, input logic [15:0] cool,
                                      input int low_pct);
      int pick;
      logic [1:0] act;
      logic [15:0] dur;
      set_limits(man_max, sch_max, cool);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) steady_flow = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 55) act = pric_pkg::ACT_TICK;
         else if (pick < 70) act = pric_pkg::ACT_MANUAL;
         else if (pick < 85) act = pric_pkg::ACT_SCHED;
         else act = pric_pkg::ACT_STOP;
         dur = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
         send_item(act, dur, 3'($urandom_range(0, 7)), $urandom_range(0, 99) >= low_pct);
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_zero_limits();
      test_stop_reasons();
      test_random_traffic(500, 16'd20, 16'd15, 16'd3, 10);
      test_random_traffic(300, 16'd0, 16'd0, 16'd0, 10);
      test_random_traffic(300, 16'd300, 16'd600, 16'd60, 5);
      test_random_traffic(300, 16'd7, 16'd9, 16'd1, 25);
      test_random_traffic(300, 16'hFFFF, 16'd1, 16'd0, 10);
      // A full-scale cooldown blocks runs for the rest of the test, so it comes last.
      test_random_traffic(150, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10);
      drain_results();
      repeat (8) @(posedge clock);
      if (status_q.size() != 0) error_count++;
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
